// ----- rtl/core/zbdt_pkg.sv -----
// Package for the z-buffer depth test and scan-out block.
// Holds field widths, request codes, the mode enum, default parameters and the store control struct.
// No dependencies.
package zbdt_pkg;

  localparam int unsigned SCREEN_SIZE_DEF = 256;
  localparam int unsigned DEPTH_BITS_DEF  = 24;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned ZIN_W   = 24;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned OUT_C_W = 8;

  localparam logic [ZIN_W-1:0] MAX_DEPTH_RESET = 24'hFF_FFFF;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_SCAN  = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'b01,
    MODE_RUN   = 2'b10
  } mode_e;

  typedef struct packed {
    logic rd_en;
    logic depth_we;
    logic color_we;
  } store_ctl_t;

endpackage

// ----- rtl/core/zbdt_pixel_store.sv -----
// Depth and color memories with registered read.
// Bypasses a write that lands on the address read in the same cycle.
// Depends on zbdt_pkg.
module zbdt_pixel_store import zbdt_pkg::*; #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = DEPTH_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  store_ctl_t         ctl_i,
  input  logic [AW-1:0]      rd_addr_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [DW-1:0]      wr_depth_i,
  input  logic [COLOR_W-1:0] wr_color_i,
  output logic [DW-1:0]      rd_depth_o,
  output logic [COLOR_W-1:0] rd_color_o
);

  localparam int unsigned DEPTH = 2 ** AW;

  logic [DW-1:0]      depth_mem [DEPTH];
  logic [COLOR_W-1:0] color_mem [DEPTH];

  logic [DW-1:0]      depth_q;
  logic [COLOR_W-1:0] color_q;
  logic [DW-1:0]      fwd_depth_q;
  logic [COLOR_W-1:0] fwd_color_q;
  logic               hit_depth_q;
  logic               hit_color_q;
  logic               same_addr;

  assign same_addr = (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.depth_we) begin
      depth_mem[wr_addr_i] <= wr_depth_i;
    end
    if (ctl_i.color_we) begin
      color_mem[wr_addr_i] <= wr_color_i;
    end
    if (ctl_i.rd_en) begin
      depth_q     <= depth_mem[rd_addr_i];
      color_q     <= color_mem[rd_addr_i];
      fwd_depth_q <= wr_depth_i;
      fwd_color_q <= wr_color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_depth_q <= 1'b0;
      hit_color_q <= 1'b0;
    end else if (ctl_i.rd_en) begin
      hit_depth_q <= ctl_i.depth_we && same_addr;
      hit_color_q <= ctl_i.color_we && same_addr;
    end
  end

  assign rd_depth_o = hit_depth_q ? fwd_depth_q : depth_q;
  assign rd_color_o = hit_color_q ? fwd_color_q : color_q;

endmodule

// ----- rtl/core/zbuffer_depth_test_scanout.sv -----
// Top level of the z-buffer depth test and raster scan-out block.
// Depends on zbdt_pkg and zbdt_pixel_store.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: x, y, depth, color; tuser: request kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: x, y, color; tuser: covered; tlast
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_data_i: max_depth
//
// One request per cycle when not stalled; scan results pass stage 1, then the output register.
// The read-modify-write loop is one memory read plus one write-back stage.
// After reset a clearing pass writes the reset depth to all 2**(2*clog2(SCREEN_SIZE))
// depth addresses (65536 by default); no request is taken during it.
// A scan request waiting on a full output register holds the pipeline; writes pass.
module zbuffer_depth_test_scanout import zbdt_pkg::*; #(
  parameter int unsigned SCREEN_SIZE = SCREEN_SIZE_DEF,
  parameter int unsigned DEPTH_BITS  = DEPTH_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [87:0]      s_axis_tdata,  // pos_x[15:0], pos_y[31:16], depth[55:32], pixel_color[87:56]
  input  logic             s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_x[7:0], out_y[15:8], out_color[47:16]
  output logic             m_axis_tuser,  // covered
  output logic             m_axis_tlast,  // frame_end
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ZIN_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(SCREEN_SIZE);
  localparam int unsigned AW = 2 * CW;
  localparam logic [CW-1:0] LAST_C = CW'(SCREEN_SIZE - 1);
  localparam logic [COORD_W-1:0] SCREEN_C = COORD_W'(SCREEN_SIZE);
  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = DEPTH_BITS'(MAX_DEPTH_RESET);

  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [ZIN_W-1:0]   in_depth;
  logic [COLOR_W-1:0] in_color;
  logic               in_acc;
  logic               in_scan;
  logic               in_live;

  mode_e              mode_q, mode_d;
  logic [AW-1:0]      clr_cnt_q;
  logic [ZIN_W-1:0]   max_depth_q;
  logic [DEPTH_BITS-1:0] maxd;
  logic [CW-1:0]      scan_x_q, scan_y_q;
  logic               scan_last;

  logic               s1_valid_q;
  logic               s1_scan_q;
  logic               s1_live_q;
  logic [AW-1:0]      s1_addr_q;
  logic [DEPTH_BITS-1:0] s1_depth_q;
  logic [COLOR_W-1:0] s1_color_q;
  logic [CW-1:0]      s1_x_q, s1_y_q;
  logic               s1_last_q;
  logic               s1_adv;
  logic               s1_cov;
  logic               s1_win;

  logic               m_valid_q;
  logic [OUT_C_W-1:0] m_x_q, m_y_q;
  logic               m_cov_q;
  logic [COLOR_W-1:0] m_color_q;
  logic               m_last_q;
  logic               m_load;

  store_ctl_t         st_ctl;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [DEPTH_BITS-1:0] wr_depth, rd_depth;
  logic [COLOR_W-1:0] rd_color;
  logic [CW+OUT_C_W-1:0] ox_ext, oy_ext;

  assign in_x     = s_axis_tdata[15:0];
  assign in_y     = s_axis_tdata[31:16];
  assign in_depth = s_axis_tdata[55:32];
  assign in_color = s_axis_tdata[87:56];
  assign in_scan  = (s_axis_tuser == REQ_SCAN);
  assign in_live  = !in_x[COORD_W-1] && (in_x < SCREEN_C)
                 && !in_y[COORD_W-1] && (in_y < SCREEN_C);

  assign maxd = DEPTH_BITS'(max_depth_q);

  assign s1_adv = s1_valid_q && (!s1_scan_q || !m_valid_q || m_axis_tready);
  assign s_axis_tready = (mode_q == MODE_RUN) && (!s1_valid_q || s1_adv);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign scan_last = (scan_x_q == LAST_C) && (scan_y_q == LAST_C);
  assign rd_addr = in_scan ? {scan_x_q, scan_y_q} : {in_x[CW-1:0], in_y[CW-1:0]};

  assign s1_cov = (rd_depth < maxd);
  assign s1_win = s1_live_q && (s1_depth_q < rd_depth);

  always_comb begin
    st_ctl.rd_en    = in_acc;
    st_ctl.depth_we = 1'b0;
    st_ctl.color_we = 1'b0;
    wr_addr         = s1_addr_q;
    wr_depth        = s1_depth_q;
    if (mode_q == MODE_CLEAR) begin
      st_ctl.depth_we = 1'b1;
      wr_addr         = clr_cnt_q;
      wr_depth        = DEPTH_RESET;
    end else if (s1_adv) begin
      if (s1_scan_q) begin
        st_ctl.depth_we = 1'b1;
        wr_depth        = maxd;
      end else if (s1_win) begin
        st_ctl.depth_we = 1'b1;
        st_ctl.color_we = 1'b1;
      end
    end
  end

  zbdt_pixel_store #(
    .AW(AW),
    .DW(DEPTH_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_depth_i(wr_depth),
    .wr_color_i(s1_color_q),
    .rd_depth_o(rd_depth),
    .rd_color_o(rd_color)
  );

  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_CLEAR: if (clr_cnt_q == '1) mode_d = MODE_RUN;
      MODE_RUN:   mode_d = MODE_RUN;
      default:    mode_d = MODE_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CLEAR;
      clr_cnt_q   <= '0;
      max_depth_q <= MAX_DEPTH_RESET;
      scan_x_q    <= '0;
      scan_y_q    <= '0;
      s1_valid_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      if (mode_q == MODE_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_valid_i) max_depth_q <= cfg_data_i;
      if (in_acc && in_scan) begin
        if (scan_y_q == LAST_C) begin
          scan_y_q <= '0;
          scan_x_q <= (scan_x_q == LAST_C) ? '0 : scan_x_q + 1'b1;
        end else begin
          scan_y_q <= scan_y_q + 1'b1;
        end
      end
      if (in_acc) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (m_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_scan_q  <= in_scan;
      s1_live_q  <= in_live;
      s1_addr_q  <= rd_addr;
      s1_depth_q <= DEPTH_BITS'(in_depth);
      s1_color_q <= in_color;
      s1_x_q     <= scan_x_q;
      s1_y_q     <= scan_y_q;
      s1_last_q  <= scan_last;
    end
  end

  assign m_load = s1_adv && s1_scan_q;
  assign ox_ext = {{OUT_C_W{1'b0}}, s1_x_q};
  assign oy_ext = {{OUT_C_W{1'b0}}, s1_y_q};

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_x_q     <= ox_ext[OUT_C_W-1:0];
      m_y_q     <= oy_ext[OUT_C_W-1:0];
      m_cov_q   <= s1_cov;
      m_color_q <= s1_cov ? rd_color : '0;
      m_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_color_q, m_y_q, m_x_q};
  assign m_axis_tuser  = m_cov_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- rtl/core/zbdt_checker.sv -----
// Port-level checker for zbuffer_depth_test_scanout, attached by bind.
// Depends on zbdt_pkg.
module zbdt_checker import zbdt_pkg::*; #(
  parameter int unsigned SCREEN_SIZE = SCREEN_SIZE_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  localparam logic [15:0] LAST16 = 16'(SCREEN_SIZE - 1);
  localparam logic [7:0]  LAST8  = LAST16[7:0];
  localparam logic [15:0] SCR16  = 16'(SCREEN_SIZE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  a_empty_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[47:16] == 32'd0)
    else $error("uncovered pixel carries a color");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == LAST8 && m_axis_tdata[15:8] == LAST8)
    else $error("frame end flagged away from the last pixel");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> SCR16 >= 16'd256
      || ({8'd0, m_axis_tdata[7:0]} < SCR16 && {8'd0, m_axis_tdata[15:8]} < SCR16))
    else $error("scanned pixel outside the screen");

endmodule

bind zbuffer_depth_test_scanout zbdt_checker #(
  .SCREEN_SIZE(SCREEN_SIZE)
) u_zbdt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for zbuffer_depth_test_scanout: depth-tested pixel writes and raster scan-out.
// Checks each scan result against directed values or an internal frame/depth predictor.
// Depends on zbdt_pkg and the RTL of the block.
module tb;
  import zbdt_pkg::*;

  localparam int unsigned SCR         = SCREEN_SIZE_DEF;
  localparam int unsigned PIX         = SCR * SCR;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic               req;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [23:0]        z;
    logic [31:0]        color;
  } frag_t;

  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic        covered;
    logic [31:0] color;
    logic        last;
  } scan_res_t;

  typedef struct {
    frag_t     f;
    bit        typed;
    scan_res_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [ZIN_W-1:0] cfg_data_i;

  logic [23:0] depth_img [PIX];
  logic [31:0] color_img [PIX];
  int unsigned scan_pos_q;
  logic [23:0] max_depth_q;

  scan_res_t   pending_scans [$];
  stim_row_t   directed_rows [$];
  int unsigned err_cnt;
  int unsigned results_seen;
  int unsigned cycle_cnt;
  bit          bursts_on;
  bit          hold_req;

  zbuffer_depth_test_scanout DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit lands(frag_t f);
    return ($unsigned(f.x) < SCR) && ($unsigned(f.y) < SCR);
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  task automatic apply_fragment(input frag_t f, output bit emits, output scan_res_t r);
    int unsigned idx;
    emits = 1'b0;
    r     = '0;
    if (f.req == REQ_WRITE) begin
      if (lands(f)) begin
        idx = $unsigned(f.x) * SCR + $unsigned(f.y);
        if (f.z < depth_img[idx]) begin
          depth_img[idx] = f.z;
          color_img[idx] = f.color;
        end
      end
    end else begin
      idx            = scan_pos_q;
      r.col          = 8'(idx / SCR);
      r.row          = 8'(idx % SCR);
      r.covered      = depth_img[idx] < max_depth_q;
      r.color        = r.covered ? color_img[idx] : '0;
      r.last         = (idx == PIX - 1);
      depth_img[idx] = max_depth_q;
      scan_pos_q     = (idx + 1) % PIX;
      emits          = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t ERROR %s: got %0h want %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic push_frag(frag_t f, bit typed, scan_res_t want);
    bit        emits;
    scan_res_t got;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {f.color, f.z, f.y, f.x};
    s_axis_tuser  <= f.req;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_fragment(f, emits, got);
    if (emits) pending_scans.insert(pending_scans.size(), typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic write_max_depth(logic [23:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_depth_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic frag_t make_fragment(int unsigned scan_pct);
    frag_t       f;
    int unsigned idx;
    int unsigned pick;
    f.req   = ($urandom_range(0, 99) < scan_pct) ? REQ_SCAN : REQ_WRITE;
    f.color = $urandom();
    case ($urandom_range(0, 4))
      0:       f.z = 24'($urandom());
      1:       f.z = 24'($urandom_range(0, 255));
      2:       f.z = 24'($urandom_range(24'hFFFF00, 24'hFFFFFF));
      3:       f.z = '0;
      default: f.z = 24'($urandom_range(0, max_depth_q));
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      // aim just ahead of the raster so scans find covered pixels
      idx = (scan_pos_q + $urandom_range(0, 300)) % PIX;
      f.x = 16'(idx / SCR);
      f.y = 16'(idx % SCR);
    end else if (pick < 16) begin
      f.x = 16'($urandom_range(0, SCR - 1));
      f.y = 16'($urandom_range(0, SCR - 1));
    end else begin
      f.x = 16'($urandom());
      f.y = 16'($urandom_range(0, SCR - 1));
      if ($urandom_range(0, 1)) {f.x, f.y} = {f.y, f.x};
    end
    return f;
  endfunction

  task automatic run_random(int unsigned scan_pct, int unsigned items, bit scans_only);
    frag_t       f;
    int unsigned n;
    n = 0;
    while (n < items) begin
      f = make_fragment(scan_pct);
      if (f.req == REQ_SCAN || (!scans_only && lands(f))) n++;
      push_frag(f, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t wr_row(logic [15:0] x, logic [15:0] y, logic [23:0] z,
                                       logic [31:0] c);
    stim_row_t r;
    r.f     = '{req: REQ_WRITE, x: x, y: y, z: z, color: c};
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t scan_row(bit typed, logic [7:0] col, logic [7:0] row,
                                         logic cov, logic [31:0] c);
    stim_row_t r;
    r.f     = '{req: REQ_SCAN, x: 16'($urandom()), y: 16'($urandom()),
                z: 24'($urandom()), color: $urandom()};
    r.typed = typed;
    r.want  = '{col: col, row: row, covered: cov, color: c, last: 1'b0};
    return r;
  endfunction

  always @(posedge clk_i) begin
    scan_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_scans.size() == 0) begin
        report_mismatch("result with none pending", 64'(m_axis_tdata), 64'd0);
      end else begin
        want = pending_scans.pop_front();
        if (m_axis_tdata[7:0] !== want.col)
          report_mismatch("out_x", 64'(m_axis_tdata[7:0]), 64'(want.col));
        if (m_axis_tdata[15:8] !== want.row)
          report_mismatch("out_y", 64'(m_axis_tdata[15:8]), 64'(want.row));
        if (m_axis_tuser !== want.covered)
          report_mismatch("covered", 64'(m_axis_tuser), 64'(want.covered));
        if (m_axis_tdata[47:16] !== want.color)
          report_mismatch("out_color", 64'(m_axis_tdata[47:16]), 64'(want.color));
        if (m_axis_tlast !== want.last)
          report_mismatch("frame_end", 64'(m_axis_tlast), 64'(want.last));
      end
      results_seen++;
      if (results_seen == 40) hold_req = 1'b1;
    end
  end

  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // hold off long enough to back the block up into its input
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (stall == 0 && bursts_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 8);
        m_axis_tready <= (stall == 0);
        if (stall != 0) stall--;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_WRITE;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    err_cnt      = 0;
    results_seen = 0;
    hold_req     = 1'b0;
    bursts_on    = 1'b1;
    scan_pos_q   = 0;
    max_depth_q  = MAX_DEPTH_RESET;
    foreach (depth_img[i]) depth_img[i] = MAX_DEPTH_RESET;
    foreach (color_img[i]) color_img[i] = '0;

    add_row(wr_row(16'd0, 16'd0, 24'd100, 32'hA1B2_C3D4));
    add_row(wr_row(16'd0, 16'd0, 24'd100, 32'hDEAD_BEEF));
    add_row(wr_row(16'd0, 16'd1, 24'd0, 32'hFFFF_FFFF));
    add_row(wr_row(16'd0, 16'd2, 24'hFF_FFFE, 32'h0000_0000));
    add_row(wr_row(16'd0, 16'd3, 24'hFF_FFFF, 32'h1234_5678));
    add_row(wr_row(16'd0, 16'd4, 24'd50, 32'h1111_1111));
    add_row(wr_row(16'd0, 16'd4, 24'd49, 32'h2222_2222));
    add_row(wr_row(16'hFFFF, 16'd5, 24'd0, 32'h3333_3333));
    add_row(wr_row(16'h8005, 16'd5, 24'd0, 32'h4444_4444));
    add_row(wr_row(16'd0, 16'h0105, 24'd0, 32'h5555_5555));
    add_row(wr_row(16'd256, 16'd5, 24'd0, 32'h5A5A_5A5A));
    add_row(wr_row(16'h7FFF, 16'h8000, 24'd0, 32'hA5A5_A5A5));
    add_row(wr_row(16'd255, 16'd255, 24'd0, 32'hCAFE_F00D));
    add_row(scan_row(1'b1, 8'd0, 8'd0, 1'b1, 32'hA1B2_C3D4));
    add_row(scan_row(1'b1, 8'd0, 8'd1, 1'b1, 32'hFFFF_FFFF));
    add_row(scan_row(1'b1, 8'd0, 8'd2, 1'b1, 32'h0000_0000));
    add_row(scan_row(1'b1, 8'd0, 8'd3, 1'b0, 32'h0000_0000));
    add_row(scan_row(1'b1, 8'd0, 8'd4, 1'b1, 32'h2222_2222));
    add_row(scan_row(1'b1, 8'd0, 8'd5, 1'b0, 32'h0000_0000));
    add_row(wr_row(16'd0, 16'd6, 24'd7, 32'h6666_6666));
    add_row(scan_row(1'b1, 8'd0, 8'd6, 1'b1, 32'h6666_6666));
    add_row(scan_row(1'b1, 8'd0, 8'd7, 1'b0, 32'h0000_0000));
    add_row(wr_row(16'd0, 16'd0, 24'd0, 32'h7777_7777));
    add_row(scan_row(1'b0, 8'd0, 8'd0, 1'b0, 32'h0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_max_depth(MAX_DEPTH_RESET);
    foreach (directed_rows[i]) push_frag(directed_rows[i].f, directed_rows[i].typed,
                                         directed_rows[i].want);
    run_random(30, 280, 1'b0);

    // lower the far plane only, so no scan can find a covered pixel with no color
    write_max_depth(24'($urandom_range(24'h10_0000, 24'hEF_FFFF)));
    run_random(50, 220, 1'b0);
    run_random(85, 200, 1'b1);

    write_max_depth(24'd1);
    run_random(50, 140, 1'b0);

    write_max_depth(24'd0);
    bursts_on = 1'b0;
    run_random(50, 200, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
